### hw/rtl/lcdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdp_pkg
// Shared constants, command codes and types for the display capture parser.
// ----------------------------------------------------------------------------
package lcdp_pkg;

   // Screen and field geometry
   localparam int SCREEN_CHARS_DEF = 32;
   localparam int FIELD_LEN        = 5;
   localparam int VOLT_FIRST       = 3;
   localparam int CURR_FIRST       = 11;
   localparam int CAP_FIRST        = 19;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int CHAR_W   = 7;
   localparam int CURSOR_W = 6;
   localparam int VALUE_W  = 27;
   localparam int CAP_W    = 17;
   localparam int ACC_W    = 17;

   // Largest legal results
   localparam logic [VALUE_W-1:0] VALUE_MAX = 27'd99999000;
   localparam logic [CAP_W-1:0]   CAP_MAX   = 17'd99999;

   // Command queue depth
   localparam int QUEUE_DEPTH = 2;

   // Special bus bytes
   localparam logic [BYTE_W-1:0] BYTE_CTRL = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_DATA = 8'h40;

   // Command kinds produced by the front end
   localparam logic [1:0] CMD_SET_CTRL = 2'd0;
   localparam logic [1:0] CMD_SET_DATA = 2'd1;
   localparam logic [1:0] CMD_PLAIN    = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data;
   } cmd_type;

endpackage
`default_nettype wire

### hw/rtl/lcdp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdp_req_if
// Request channel: bus bytes and parse requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcdp_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [lcdp_pkg::BYTE_W-1:0] bus_byte;

   modport source (output valid, req_type, bus_byte, input ready);
   modport sink   (input valid, req_type, bus_byte, output ready);
endinterface
`default_nettype wire

### hw/rtl/lcdp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdp_rsp_if
// Response channel: parsed voltage, current and capacity with valid/ready.
// ----------------------------------------------------------------------------
interface lcdp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcdp_pkg::VALUE_W-1:0] voltage_mv;
   logic [lcdp_pkg::VALUE_W-1:0] current_ma;
   logic [lcdp_pkg::CAP_W-1:0]   capacity_mah;

   modport source (output valid, voltage_mv, current_ma, capacity_mah, input ready);
   modport sink   (input valid, voltage_mv, current_ma, capacity_mah, output ready);
endinterface
`default_nettype wire

### hw/rtl/lcd_text_capture_field_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_text_capture_field_parser
// Character display capture with a three-field measurement parser.
// ----------------------------------------------------------------------------
// Each request is either a bus byte (req_type 0) that updates the display
// image, or a parse request (req_type 1) that returns voltage, current and
// capacity. Requests are classified on arrival and queued two deep, so the
// port keeps accepting while the back end works, until the queue is full.
// A parse request leaves the queue, scans its fields one character per cycle
// from the screen register file, then scales each decimal field to thousandths
// through a shared times-ten / divide-by-ten unit, and loads the output
// register. The output register holds a result until it is taken while
// further bus bytes keep flowing.
// ----------------------------------------------------------------------------
module lcd_text_capture_field_parser #(
   parameter int SCREEN_CHARS = lcdp_pkg::SCREEN_CHARS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lcdp_req_if.sink   req_bus,
   lcdp_rsp_if.source rsp_bus
);
   import lcdp_pkg::*;

   cmd_type head_cmd;
   logic    head_valid;
   logic    head_pop;

   // Accept and classify
   lcdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Execute and parse
   lcdp_back #(
      .SCREEN_CHARS (SCREEN_CHARS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_bus    (rsp_bus)
   );

   // No result survives reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   // Scaled voltage stays within five digits times a thousand
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.voltage_mv <= VALUE_MAX))
      else $error("voltage out of range");

   // Scaled current stays within five digits times a thousand
   a_curr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.current_ma <= VALUE_MAX))
      else $error("current out of range");

   // Capacity is at most five digits
   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.capacity_mah <= CAP_MAX))
      else $error("capacity out of range");

endmodule
`default_nettype wire

### hw/rtl/lcdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdp_front
// Accepts requests, classifies each into a command and queues it for the
// back end in a short FIFO.
// ----------------------------------------------------------------------------
module lcdp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   lcdp_req_if.sink               req_bus,
   output lcdp_pkg::cmd_type      head_cmd,
   output logic                   head_valid,
   input  wire logic              head_pop
);
   import lcdp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cmd_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   cmd_type          new_cmd;
   logic             push;
   logic             pop;

   // Classify the incoming request
   always_comb begin
      new_cmd.data = req_bus.bus_byte;
      if (req_bus.req_type) begin
         new_cmd.kind = CMD_READ;
      end else if (req_bus.bus_byte == BYTE_CTRL) begin
         new_cmd.kind = CMD_SET_CTRL;
      end else if (req_bus.bus_byte == BYTE_DATA) begin
         new_cmd.kind = CMD_SET_DATA;
      end else begin
         new_cmd.kind = CMD_PLAIN;
      end
   end

   // Handshake on both sides of the queue
   assign req_bus.ready = (fill_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign head_valid    = (fill_ff != '0);
   assign pop           = head_pop && head_valid;
   assign head_cmd      = store_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/lcdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdp_back
// Executes queued commands: keeps the screen image, cursor and byte mode,
// and scans the three measurement fields one character per cycle.
// ----------------------------------------------------------------------------
module lcdp_back #(
   parameter int SCREEN_CHARS = lcdp_pkg::SCREEN_CHARS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lcdp_pkg::cmd_type head_cmd,
   input  wire logic              head_valid,
   output logic                   head_pop,
   lcdp_rsp_if.source             rsp_bus
);
   import lcdp_pkg::*;

   localparam int IDX_W = $clog2(SCREEN_CHARS);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SCALE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Byte modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_CTRL = 2'd1;
   localparam logic [1:0] MODE_DATA = 2'd2;

   // Field selects
   localparam logic [1:0] FIELD_VOLT = 2'd0;
   localparam logic [1:0] FIELD_CURR = 2'd1;
   localparam logic [1:0] FIELD_CAP  = 2'd2;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

   // Cursor control
   localparam logic [1:0]          ADDR_ROW1  = 2'b10;
   localparam logic [1:0]          ADDR_ROW2  = 2'b11;
   localparam logic [CURSOR_W-1:0] ROW2_BASE  = 6'd16;
   localparam logic [2:0]          FRAC_UNITS = 3'd3;
   localparam logic [2:0]          LAST_POS   = 3'(FIELD_LEN - 1);

   // Reciprocal of ten, exact for dividends below 2^17
   localparam logic [20:0] DIV10_RECIP = 21'd104858;

   logic [CHAR_W-1:0]   screen_ff [SCREEN_CHARS];
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [1:0]          mode_ff, mode_in;
   logic [1:0]          state_ff, state_in;
   logic [1:0]          field_ff, field_in;
   logic [2:0]          pos_ff, pos_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [2:0]          pt_ff, pt_in;
   logic                stop_ff, stop_in;
   logic [VALUE_W-1:0]  volt_ff, volt_in;
   logic [VALUE_W-1:0]  curr_ff, curr_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [2:0]          vfrac_ff, vfrac_in;
   logic [2:0]          cfrac_ff, cfrac_in;
   logic                sel_ff, sel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_volt_ff;
   logic [VALUE_W-1:0]  rsp_curr_ff;
   logic [CAP_W-1:0]    rsp_cap_ff;

   logic                take_cmd;
   logic                do_plain;
   logic                do_clear;
   logic                do_store;
   logic                rsp_load;
   logic [IDX_W-1:0]    scan_addr;
   logic [CHAR_W-1:0]   scan_char;
   logic                char_digit;
   logic [ACC_W-1:0]    acc_x10;
   logic [ACC_W-1:0]    acc_dig;
   logic [VALUE_W-1:0]  scale_val;
   logic [2:0]          scale_frac;
   logic [VALUE_W-1:0]  val_x10;
   logic [37:0]         div_prod;
   logic [VALUE_W-1:0]  val_div10;

   // Pop a command only while no request is in flight
   assign take_cmd = head_valid && (state_ff == ST_IDLE);
   assign head_pop = take_cmd;
   assign do_plain = take_cmd && (head_cmd.kind == CMD_PLAIN);
   assign do_clear = do_plain && (mode_ff == MODE_CTRL) &&
                     (head_cmd.data[7:6] != ADDR_ROW1) && (head_cmd.data[7:6] != ADDR_ROW2);
   assign do_store = do_plain && (mode_ff == MODE_DATA) &&
                     (cursor_ff < CURSOR_W'(SCREEN_CHARS));

   // Select the character under scan
   always_comb begin
      unique case (field_ff)
         FIELD_VOLT: scan_addr = IDX_W'(VOLT_FIRST) + IDX_W'(pos_ff);
         FIELD_CURR: scan_addr = IDX_W'(CURR_FIRST) + IDX_W'(pos_ff);
         default:    scan_addr = IDX_W'(CAP_FIRST) + IDX_W'(pos_ff);
      endcase
   end

   assign scan_char  = screen_ff[scan_addr];
   assign char_digit = (scan_char >= CHAR_ZERO) && (scan_char <= CHAR_NINE);
   assign acc_x10    = ACC_W'({acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0});
   assign acc_dig    = acc_x10 + ACC_W'(scan_char[3:0]);

   // Shared scaling unit: times ten by shift-add, divide by ten by reciprocal
   assign scale_val  = sel_ff ? curr_ff : volt_ff;
   assign scale_frac = sel_ff ? cfrac_ff : vfrac_ff;
   assign val_x10    = VALUE_W'({scale_val, 3'b000} + {2'b00, scale_val, 1'b0});
   assign div_prod   = scale_val[ACC_W-1:0] * DIV10_RECIP;
   assign val_div10  = VALUE_W'(div_prod[36:20]);

   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // Byte mode and cursor
   always_comb begin
      mode_in   = mode_ff;
      cursor_in = cursor_ff;
      if (take_cmd) begin
         unique case (head_cmd.kind)
            CMD_SET_CTRL: mode_in = MODE_CTRL;
            CMD_SET_DATA: mode_in = MODE_DATA;
            CMD_PLAIN: begin
               mode_in = MODE_NONE;
               if (mode_ff == MODE_CTRL) begin
                  if (head_cmd.data[7:6] == ADDR_ROW1) begin
                     cursor_in = CURSOR_W'(head_cmd.data[4:0]);
                  end else if (head_cmd.data[7:6] == ADDR_ROW2) begin
                     cursor_in = ROW2_BASE + CURSOR_W'(head_cmd.data[4:0]);
                  end
               end else if (do_store) begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Scan sequencer and field scaling
   always_comb begin
      state_in = state_ff;
      field_in = field_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      pt_in    = pt_ff;
      stop_in  = stop_ff;
      volt_in  = volt_ff;
      curr_in  = curr_ff;
      cap_in   = cap_ff;
      vfrac_in = vfrac_ff;
      cfrac_in = cfrac_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_cmd && (head_cmd.kind == CMD_READ)) begin
               state_in = ST_SCAN;
               field_in = FIELD_VOLT;
               pos_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
               pt_in    = '0;
               stop_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (field_ff != FIELD_CAP) begin
               if (char_digit) begin
                  acc_in = acc_dig;
                  cnt_in = cnt_ff + 1'b1;
               end else if (scan_char == CHAR_DOT) begin
                  pt_in = cnt_ff;
               end else if (scan_char == CHAR_SPACE) begin
                  acc_in = acc_x10;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (!stop_ff) begin
               if (char_digit) begin
                  acc_in = acc_dig;
                  cnt_in = cnt_ff + 1'b1;
               end else if ((scan_char == CHAR_SPACE) && (cnt_ff != '0)) begin
                  stop_in = 1'b1;
               end
            end
            if (pos_ff == LAST_POS) begin
               // Close the field and start the next one
               unique case (field_ff)
                  FIELD_VOLT: begin
                     volt_in  = VALUE_W'(acc_in);
                     vfrac_in = cnt_in - pt_in;
                  end
                  FIELD_CURR: begin
                     curr_in  = VALUE_W'(acc_in);
                     cfrac_in = cnt_in - pt_in;
                  end
                  default: begin
                     cap_in   = CAP_W'(acc_in);
                     state_in = ST_SCALE;
                     sel_in   = 1'b0;
                  end
               endcase
               field_in = field_ff + 1'b1;
               pos_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
               pt_in    = '0;
               stop_in  = 1'b0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            if (scale_frac != FRAC_UNITS) begin
               if (sel_ff) begin
                  curr_in  = (scale_frac < FRAC_UNITS) ? val_x10 : val_div10;
                  cfrac_in = (scale_frac < FRAC_UNITS) ? cfrac_ff + 1'b1 : cfrac_ff - 1'b1;
               end else begin
                  volt_in  = (scale_frac < FRAC_UNITS) ? val_x10 : val_div10;
                  vfrac_in = (scale_frac < FRAC_UNITS) ? vfrac_ff + 1'b1 : vfrac_ff - 1'b1;
               end
            end else if (!sel_ff) begin
               sel_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold a finished result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_NONE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan and scaling datapath
   always_ff @(posedge clock) begin
      field_ff <= field_in;
      pos_ff   <= pos_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      pt_ff    <= pt_in;
      stop_ff  <= stop_in;
      volt_ff  <= volt_in;
      curr_ff  <= curr_in;
      cap_ff   <= cap_in;
      vfrac_ff <= vfrac_in;
      cfrac_ff <= cfrac_in;
      sel_ff   <= sel_in;
      if (rsp_load) begin
         rsp_volt_ff <= volt_ff;
         rsp_curr_ff <= curr_ff;
         rsp_cap_ff  <= cap_ff;
      end
   end

   // Screen image: fill on clear, write at cursor on data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SCREEN_CHARS; k++) begin
            screen_ff[k] <= CHAR_DASH;
         end
      end else if (do_clear) begin
         for (int k = 0; k < SCREEN_CHARS; k++) begin
            screen_ff[k] <= CHAR_COLON;
         end
      end else if (do_store) begin
         screen_ff[cursor_ff[IDX_W-1:0]] <= head_cmd.data[CHAR_W-1:0];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.voltage_mv   = rsp_volt_ff;
   assign rsp_bus.current_ma   = rsp_curr_ff;
   assign rsp_bus.capacity_mah = rsp_cap_ff;

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display capture field parser. Bus bytes build
// a screen image in a local copy of the display; each parse request predicts
// voltage, current and capacity, which are matched against the response port
// in order. Both ports idle at random, with one stretch running flat out.
// ----------------------------------------------------------------------------
module tb_top;
   import lcdp_pkg::*;

   // Request kinds on the input channel
   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_PARSE = 1'b1;

   // Control byte decoding
   localparam logic [7:0] CTRL_MASK   = 8'hC0;
   localparam logic [7:0] CTRL_ROW0   = 8'h80;
   localparam logic [7:0] CTRL_ROW1   = 8'hC0;
   localparam logic [7:0] CURSOR_MASK = 8'h1F;
   localparam int         ROW_CHARS   = 16;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

   localparam int IDLE_PCT     = 22;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic [1:0] {MODE_IDLE, MODE_CTRL, MODE_DATA} byte_mode_e;

   typedef struct {
      logic [VALUE_W-1:0] voltage_mv;
      logic [VALUE_W-1:0] current_ma;
      logic [CAP_W-1:0]   capacity_mah;
   } reading_t;

   // Display image, cursor and byte mode tracked alongside the block
   class display_scoreboard;
      logic [CHAR_W-1:0]   screen [SCREEN_CHARS_DEF];
      logic [CURSOR_W-1:0] cursor;
      byte_mode_e          mode;
      reading_t            readings_q [$];
      int                  fail_count;

      function new();
         foreach (screen[k]) screen[k] = CH_DASH;
         cursor     = '0;
         mode       = MODE_IDLE;
         fail_count = 0;
      endfunction

      // Apply one bus byte to the display image
      function void take_bus_byte(logic [7:0] b);
         if (b == BYTE_CTRL) begin
            mode = MODE_CTRL;
            return;
         end
         if (b == BYTE_DATA) begin
            mode = MODE_DATA;
            return;
         end
         if (mode == MODE_CTRL) begin
            if ((b & CTRL_MASK) == CTRL_ROW0)
               cursor = CURSOR_W'(b & CURSOR_MASK);
            else if ((b & CTRL_MASK) == CTRL_ROW1)
               cursor = CURSOR_W'(ROW_CHARS + (b & CURSOR_MASK));
            else
               foreach (screen[k]) screen[k] = CH_COLON;
         end else if (mode == MODE_DATA && cursor < SCREEN_CHARS_DEF) begin
            screen[cursor] = b[CHAR_W-1:0];
            cursor++;
         end
         mode = MODE_IDLE;
      endfunction

      // Decimal field with point, scaled to thousandths
      function logic [VALUE_W-1:0] decimal_field(int first);
         int unsigned       value;
         int unsigned       count;
         int unsigned       point;
         int unsigned       frac;
         logic [CHAR_W-1:0] c;
         value = 0;
         count = 0;
         point = 0;
         for (int k = first; k < first + FIELD_LEN; k++) begin
            c = screen[k];
            if (c >= CH_ZERO && c <= CH_NINE) begin
               value = value * 10 + (c - CH_ZERO);
               count++;
            end else if (c == CH_POINT) begin
               point = count;
            end else if (c == CH_SPACE) begin
               value = value * 10;
               count++;
            end
         end
         frac = count - point;
         while (frac < 3) begin
            value = value * 10;
            frac++;
         end
         while (frac > 3) begin
            value = value / 10;
            frac--;
         end
         return value[VALUE_W-1:0];
      endfunction

      // Plain integer field; a space after a digit ends it
      function logic [CAP_W-1:0] integer_field(int first);
         int unsigned       value;
         int unsigned       count;
         logic [CHAR_W-1:0] c;
         value = 0;
         count = 0;
         for (int k = first; k < first + FIELD_LEN; k++) begin
            c = screen[k];
            if (c >= CH_ZERO && c <= CH_NINE) begin
               value = value * 10 + (c - CH_ZERO);
               count++;
            end else if (c == CH_SPACE && count > 0) begin
               break;
            end
         end
         return value[CAP_W-1:0];
      endfunction

      // Note an accepted request
      function void note_request(logic kind, logic [7:0] b);
         reading_t r;
         if (kind == REQ_BYTE) begin
            take_bus_byte(b);
         end else begin
            r.voltage_mv   = decimal_field(VOLT_FIRST);
            r.current_ma   = decimal_field(CURR_FIRST);
            r.capacity_mah = integer_field(CAP_FIRST);
            readings_q.push_back(r);
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         fail_count++;
      endtask

      // Match a response against the oldest predicted reading
      task check_reading(reading_t got);
         reading_t want;
         if (readings_q.size() == 0) begin
            report($sformatf("unexpected response v=%0d i=%0d cap=%0d",
                   got.voltage_mv, got.current_ma, got.capacity_mah));
            return;
         end
         want = readings_q.pop_front();
         if (got.voltage_mv !== want.voltage_mv)
            report($sformatf("voltage_mv got %0d want %0d",
                   got.voltage_mv, want.voltage_mv));
         if (got.current_ma !== want.current_ma)
            report($sformatf("current_ma got %0d want %0d",
                   got.current_ma, want.current_ma));
         if (got.capacity_mah !== want.capacity_mah)
            report($sformatf("capacity_mah got %0d want %0d",
                   got.capacity_mah, want.capacity_mah));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady_run;
   int   items_sent;

   display_scoreboard sb;

   lcdp_req_if req_bus ();
   lcdp_rsp_if rsp_bus ();

   lcd_text_capture_field_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hold one request until accepted, idling at random before it
   task automatic send_request(input logic kind, input logic [7:0] b);
      if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock);
         while (!steady_run && $urandom_range(99) < IDLE_PCT);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.bus_byte <= b;
      do @(posedge clock);
      while (!req_bus.ready);
      sb.note_request(kind, b);
      items_sent++;
   endtask

   task automatic control_byte(input logic [7:0] b);
      send_request(REQ_BYTE, BYTE_CTRL);
      send_request(REQ_BYTE, b);
   endtask

   task automatic put_char(input logic [7:0] c);
      send_request(REQ_BYTE, BYTE_DATA);
      send_request(REQ_BYTE, c);
   endtask

   task automatic request_reading();
      send_request(REQ_PARSE, 8'($urandom));
   endtask

   // Cursor command for a position, either row encoding where both reach it
   function automatic logic [7:0] cursor_cmd(int p);
      logic [7:0] b;
      if (p >= SCREEN_CHARS_DEF || (p >= ROW_CHARS && $urandom_range(1) == 1))
         b = CTRL_ROW1 | 8'(p - ROW_CHARS);
      else
         b = CTRL_ROW0 | 8'(p);
      b[5] = 1'($urandom_range(1));
      return b;
   endfunction

   // Mostly digits, some spaces and points, a few odd characters
   function automatic logic [7:0] pick_char();
      int         r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (r < 55)      c = 8'(CH_ZERO) + 8'($urandom_range(9));
      else if (r < 70) c = 8'(CH_SPACE);
      else if (r < 82) c = 8'(CH_POINT);
      else             c = 8'($urandom);
      if ($urandom_range(4) == 0)
         c[7] = 1'b1;
      return c;
   endfunction

   // Response side: random backpressure, check each accepted response
   initial begin
      reading_t got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.voltage_mv   = rsp_bus.voltage_mv;
            got.current_ma   = rsp_bus.current_ma;
            got.capacity_mah = rsp_bus.capacity_mah;
            sb.check_reading(got);
         end
         rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Stimulus
   initial begin
      int         r;
      int         n;
      int         pos;
      logic [7:0] b;
      sb         = new();
      steady_run = 1'b0;
      items_sent = 0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_BYTE;
      req_bus.bus_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset image, ignored byte, clear, short decimal field,
      // cursor past the end, last cell, full screen drop
      request_reading();
      send_request(REQ_BYTE, 8'h41);
      control_byte(8'h3F);
      request_reading();
      control_byte(CTRL_ROW0 | 8'(VOLT_FIRST));
      put_char(8'(CH_ZERO) + 8'd1);
      put_char(8'(CH_POINT));
      put_char(8'hB9);
      request_reading();
      control_byte(8'hDF);
      put_char(8'h35);
      control_byte(8'h9F);
      put_char(8'(CH_NINE) - 8'd2);
      put_char(8'(CH_NINE) - 8'd1);
      send_request(REQ_PARSE, 8'hFF);

      // Random: mostly field writes followed by a parse, some noise
      while (items_sent < RANDOM_ITEMS + 25) begin
         steady_run = (items_sent >= 320 && items_sent < 470);
         r = $urandom_range(99);
         if (r < 60) begin
            case ($urandom_range(4))
               0:       pos = VOLT_FIRST + $urandom_range(2) - 1;
               1:       pos = CURR_FIRST + $urandom_range(2) - 1;
               2:       pos = CAP_FIRST + $urandom_range(2) - 1;
               3:       pos = $urandom_range(SCREEN_CHARS_DEF - 1);
               default: pos = $urandom_range(2 * ROW_CHARS + 15);
            endcase
            control_byte(cursor_cmd(pos));
            n = $urandom_range(7, 1);
            repeat (n) put_char(pick_char());
            if ($urandom_range(99) < 60)
               request_reading();
         end else if (r < 70) begin
            request_reading();
         end else if (r < 75) begin
            // clear: control byte whose top bits are neither row pattern
            b = 8'($urandom_range(127, 1));
            if (b == BYTE_DATA)
               b = 8'h7F;
            control_byte(b);
         end else if (r < 85) begin
            send_request(REQ_BYTE, $urandom_range(1) ? BYTE_CTRL : BYTE_DATA);
            send_request(REQ_BYTE, 8'($urandom));
         end else begin
            send_request(REQ_BYTE, 8'($urandom));
         end
      end
      steady_run = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain outstanding readings, then let the back end settle
      while (sb.readings_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("** lcd_text_capture_field_parser: PASSED **");
      else
         $display("** lcd_text_capture_field_parser: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("** lcd_text_capture_field_parser: FAILED **");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lcdp_pkg.sv
hw/rtl/lcdp_req_if.sv
hw/rtl/lcdp_rsp_if.sv
hw/rtl/lcdp_front.sv
hw/rtl/lcdp_back.sv
hw/rtl/lcd_text_capture_field_parser.sv
tb/tb_top.sv
